[sv/dcq_pkg.sv]
// shared types and constants of the delayed command queue
package dcq_pkg;

   // default sizes, handed to the top level parameters
   localparam int TABLE_DEPTH_DEF   = 16;
   localparam int PAYLOAD_WIDTH_DEF = 32;

   // fixed field widths of the transaction payloads
   localparam int CODE_W  = 8;
   localparam int DELAY_W = 16;
   localparam int DATA_W  = 32;

   // request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // request transaction
   typedef struct packed {
      logic              req_type;
      logic [CODE_W-1:0]  cmd_code;
      logic [DELAY_W-1:0] delay_ticks;
      logic [DATA_W-1:0]  payload;
   } req_item_type;

   // response transaction
   typedef struct packed {
      logic              fired;
      logic [CODE_W-1:0] fired_code;
      logic [DATA_W-1:0] fired_payload;
      logic              accepted;
      logic              last;
   } rsp_item_type;

   // commands from controller to datapath
   typedef struct packed {
      logic push;
      logic tick_start;
      logic walk;
      logic finish;
   } dcq_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic walk_done;
   } dcq_stat_type;

endpackage

[sv/delayed_command_queue.sv]
// Delayed command queue: an insertion-ordered table of pending commands.
// Requests enter on req_item and are taken at a clock edge where start is
// high and busy is low. A push appends a command (code, delay, payload) or
// is dropped when the table is full; it answers with one response with
// accepted set or clear and last set in the cycle after acceptance, and busy
// never rises for it. A tick walks the stored commands oldest first through
// one memory read port: each entry with a nonzero delay is decremented and
// written back compacted, each entry with a zero delay fires and is removed.
// A tick keeps busy high while it walks the stored entries. Fired commands
// come out oldest first, one response per fired command, the last one
// marked by last; a tick that fires nothing gives one response with only
// last set. Each response is on rsp_item for exactly one cycle, marked by
// rsp_strobe; the receiver cannot stall, so nothing is held back. A
// synchronous reset empties the table and returns the block to idle.
module delayed_command_queue #(
   parameter int TABLE_DEPTH   = dcq_pkg::TABLE_DEPTH_DEF,
   parameter int PAYLOAD_WIDTH = dcq_pkg::PAYLOAD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dcq_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output dcq_pkg::rsp_item_type rsp_item
);
   import dcq_pkg::*;

   dcq_cmd_type  cmd;
   dcq_stat_type stat;

   // sequencing
   dcq_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_item.req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // table and response path
   dcq_datapath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

[sv/dcq_datapath.sv]
// command table memory, walk counters, pending fire holder and response register
module dcq_datapath #(
   parameter int TABLE_DEPTH   = 16,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dcq_pkg::req_item_type req_item,
   input  dcq_pkg::dcq_cmd_type  cmd,
   output dcq_pkg::dcq_stat_type stat,
   output logic                  rsp_strobe,
   output dcq_pkg::rsp_item_type rsp_item
);
   import dcq_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int PW    = PAYLOAD_WIDTH;

   // table storage
   logic [CODE_W-1:0]  mem_code    [TABLE_DEPTH];
   logic [DELAY_W-1:0] mem_delay   [TABLE_DEPTH];
   logic [PW-1:0]      mem_payload [TABLE_DEPTH];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [CNT_W-1:0]   wr_ff, wr_in;
   logic               eval_ff, eval_in;
   logic [CODE_W-1:0]  rd_code_ff;
   logic [DELAY_W-1:0] rd_delay_ff;
   logic [PW-1:0]      rd_payload_ff;
   logic               pend_ff, pend_in;
   logic [CODE_W-1:0]  pend_code_ff, pend_code_in;
   logic [PW-1:0]      pend_payload_ff, pend_payload_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               full;
   logic               rd_en;
   logic               fire;
   logic               keep;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [CODE_W-1:0]  mem_wcode;
   logic [DELAY_W-1:0] mem_wdelay;
   logic [PW-1:0]      mem_wpayload;
   logic [PW+DATA_W-1:0] push_payload_wide;
   logic [PW+DATA_W-1:0] pend_payload_wide;
   logic [DATA_W-1:0]  pend_payload_out;

   // payload width conversion between the port and the table
   assign push_payload_wide = {{PW{1'b0}}, req_item.payload};
   assign pend_payload_wide = {{DATA_W{1'b0}}, pend_payload_ff};
   assign pend_payload_out  = pend_payload_wide[DATA_W-1:0];

   // walk decisions
   assign full  = (count_ff == CNT_W'(TABLE_DEPTH));
   assign rd_en = cmd.walk && (issue_ff != count_ff);
   assign fire  = eval_ff && (rd_delay_ff == '0);
   assign keep  = eval_ff && (rd_delay_ff != '0);
   assign stat.walk_done = (issue_ff == count_ff) && !eval_ff;

   // single write port: append on push, compact survivors on tick
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = wr_ff[IDX_W-1:0];
      mem_wcode    = rd_code_ff;
      mem_wdelay   = rd_delay_ff - DELAY_W'(1);
      mem_wpayload = rd_payload_ff;
      if (cmd.push) begin
         mem_we       = !full;
         mem_waddr    = count_ff[IDX_W-1:0];
         mem_wcode    = req_item.cmd_code;
         mem_wdelay   = req_item.delay_ticks;
         mem_wpayload = push_payload_wide[PW-1:0];
      end else if (keep) begin
         mem_we = 1'b1;
      end
   end

   // table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_code[mem_waddr]    <= mem_wcode;
         mem_delay[mem_waddr]   <= mem_wdelay;
         mem_payload[mem_waddr] <= mem_wpayload;
      end
      if (rd_en) begin
         rd_code_ff    <= mem_code[issue_ff[IDX_W-1:0]];
         rd_delay_ff   <= mem_delay[issue_ff[IDX_W-1:0]];
         rd_payload_ff <= mem_payload[issue_ff[IDX_W-1:0]];
      end
   end

   // counters and pending fire
   always_comb begin
      count_in        = count_ff;
      issue_in        = issue_ff;
      wr_in           = wr_ff;
      eval_in         = rd_en;
      pend_in         = pend_ff;
      pend_code_in    = pend_code_ff;
      pend_payload_in = pend_payload_ff;
      if (cmd.push && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.tick_start) begin
         issue_in = '0;
         wr_in    = '0;
         pend_in  = 1'b0;
      end
      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end
      if (keep) begin
         wr_in = wr_ff + CNT_W'(1);
      end
      if (fire) begin
         pend_in         = 1'b1;
         pend_code_in    = rd_code_ff;
         pend_payload_in = rd_payload_ff;
      end
      if (cmd.finish) begin
         count_in = wr_ff;
         pend_in  = 1'b0;
      end
   end

   // response register: push result, delayed fire results, final result
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '0;
      if (cmd.push) begin
         rsp_strobe_in        = 1'b1;
         rsp_item_in.accepted = !full;
         rsp_item_in.last     = 1'b1;
      end else if (fire && pend_ff) begin
         rsp_strobe_in             = 1'b1;
         rsp_item_in.fired         = 1'b1;
         rsp_item_in.fired_code    = pend_code_ff;
         rsp_item_in.fired_payload = pend_payload_out;
      end else if (cmd.finish) begin
         rsp_strobe_in    = 1'b1;
         rsp_item_in.last = 1'b1;
         if (pend_ff) begin
            rsp_item_in.fired         = 1'b1;
            rsp_item_in.fired_code    = pend_code_ff;
            rsp_item_in.fired_payload = pend_payload_out;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         issue_ff      <= '0;
         wr_ff         <= '0;
         eval_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         wr_ff         <= wr_in;
         eval_ff       <= eval_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_code_ff    <= pend_code_in;
      pend_payload_ff <= pend_payload_in;
      rsp_item_ff     <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // fill level never passes the table size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // compaction write pointer never overtakes the read pointer
   assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> wr_ff <= issue_ff)
      else $error("compaction pointer ahead of read pointer");

   // every finished walk ends in a last response
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_strobe_ff && rsp_item_ff.last)
      else $error("walk finished without final response");

endmodule

[sv/dcq_controller.sv]
// controller state machine: accepts requests and sequences the tick walk
module dcq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_kind,
   input  dcq_pkg::dcq_stat_type stat,
   output dcq_pkg::dcq_cmd_type  cmd,
   output logic                  busy
);
   import dcq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } dcq_state_type;

   dcq_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == REQ_TICK) begin
                  cmd.tick_start = 1'b1;
                  state_in       = ST_WALK;
               end else begin
                  cmd.push = 1'b1;
               end
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // an accepted tick holds the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == REQ_TICK |=> busy)
      else $error("tick accepted without starting walk");

   // a push leaves the block idle in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == REQ_PUSH |=> !busy)
      else $error("push left block busy");

   // finishing a walk releases the block
   assert property (@(posedge clock) disable iff (reset)
      busy && stat.walk_done |=> !busy)
      else $error("block stayed busy after walk");

endmodule
